@@ design/wlm_pkg.sv @@
// wildcard line matcher package: request codes, pattern codes, characters,
// cell control and status structs, and the case fold helper
// no dependencies
package wlm_pkg;

  // default pattern store depth
  localparam int unsigned DEPTH_DEFAULT = 64;

  // request commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEXT   = 2'd2;
  localparam logic [1:0] CMD_EOL    = 2'd3;

  // stored pattern codes, anything else is a literal byte
  localparam logic [7:0] CODE_STAR  = 8'd1;
  localparam logic [7:0] CODE_ANY   = 8'd2;
  localparam logic [7:0] CODE_OPEN  = 8'd3;
  localparam logic [7:0] CODE_CLOSE = 8'd4;

  // characters with a meaning
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUEST     = 8'h3F;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK    = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK    = 8'h5D;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // pass of the shared carry unit
  typedef enum logic [1:0] {
    PH_CLOSURE,
    PH_CHAIN,
    PH_CONSUME
  } phase_t;

  // broadcast to every cell
  typedef struct packed {
    phase_t     phase;
    logic       step;
    logic       restart;
    logic       inject;
    logic       load;
    logic [7:0] code;
    logic [7:0] text;
  } cell_ctrl_t;

  // returned by every cell
  typedef struct packed {
    logic gen;
    logic prop;
    logic adv;
    logic acc;
  } cell_stat_t;

  // lower case a-z when folding is on
  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ design/wlm_in_if.sv @@
// request channel of the wildcard line matcher: valid, ready, cmd and byte
// depends on nothing
interface wlm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_byte;

  modport source (output valid, output cmd, output char_byte, input ready);
  modport sink (input valid, input cmd, input char_byte, output ready);
endinterface

@@ design/wlm_out_if.sv @@
// result channel of the wildcard line matcher: valid, ready and two flags
// depends on nothing
interface wlm_out_if;
  logic valid;
  logic ready;
  logic line_matched;
  logic pattern_truncated;

  modport source (output valid, output line_matched, output pattern_truncated, input ready);
  modport sink (input valid, input line_matched, input pattern_truncated, output ready);
endinterface

@@ design/wlm_carry.sv @@
// shared carry unit: carry into every cell from per-cell generate and
// propagate, worked out with one wide add; uses wlm_pkg for the default width
module wlm_carry #(
  parameter int unsigned WIDTH = wlm_pkg::DEPTH_DEFAULT
) (
  input  logic [WIDTH-1:0] gen,
  input  logic [WIDTH-1:0] prop,
  output logic [WIDTH-1:0] cin
);

  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] sum;

  // gen + (gen | prop) carries through propagate cells, starts at generate
  assign addend = gen | prop;
  assign sum    = gen + addend;
  assign cin    = sum ^ gen ^ addend;

endmodule

@@ design/wlm_cell.sv @@
// one pattern position: holds its code, its active bit and the two pass
// results; uses wlm_pkg for codes and the control and status structs
module wlm_cell #(
  parameter int unsigned PATTERN_DEPTH = wlm_pkg::DEPTH_DEFAULT,
  parameter int unsigned IDX           = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  wlm_pkg::cell_ctrl_t                ctrl,
  input  logic [$clog2(PATTERN_DEPTH+1)-1:0] len,
  input  logic                               cin,
  input  logic                               adv_left,
  output wlm_pkg::cell_stat_t                stat
);
  import wlm_pkg::*;

  localparam int unsigned LW = $clog2(PATTERN_DEPTH + 1);
  localparam logic IS_FIRST = (IDX == 0);

  logic [7:0] code;
  logic       active;
  logic       closed;
  logic       in_class;

  logic valid, last, is_star, is_any, is_open, is_close, is_lit, hit;
  logic x_set, closed_now, fire, adv, next_active;

  // position decode
  assign valid = LW'(IDX) < len;
  assign last  = len == LW'(IDX + 1);

  // code decode
  assign is_star  = code == CODE_STAR;
  assign is_any   = code == CODE_ANY;
  assign is_open  = code == CODE_OPEN;
  assign is_close = code == CODE_CLOSE;
  assign is_lit   = !(is_star || is_any || is_open || is_close);
  assign hit      = code == ctrl.text;

  // set before closure, with the start position injected
  assign x_set      = active | (IS_FIRST & ctrl.inject);
  assign closed_now = valid & (x_set | cin);

  // class close fires when an active open and a member hit came before it
  assign fire        = valid & is_close & cin;
  assign adv         = valid & ((closed & (is_any | (is_lit & hit))) | fire);
  assign next_active = valid & ((closed & is_star) | adv_left);

  // generate and propagate for the current pass
  always_comb begin
    stat.gen  = 1'b0;
    stat.prop = 1'b0;
    stat.acc  = 1'b0;
    unique case (ctrl.phase)
      PH_CLOSURE: begin
        stat.gen  = valid & x_set & is_star;
        stat.prop = valid & is_star;
        stat.acc  = last & closed_now & is_star;
      end
      PH_CHAIN: begin
        stat.gen  = valid & closed & is_open;
        stat.prop = valid & ~is_close;
      end
      PH_CONSUME: begin
        stat.gen  = valid & in_class & hit & ~is_close;
        stat.prop = valid & ~is_close;
        stat.acc  = last & adv;
      end
      default: begin
        stat.gen  = 1'b0;
        stat.prop = 1'b0;
        stat.acc  = 1'b0;
      end
    endcase
    stat.adv = adv;
  end

  // active bit
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= IS_FIRST;
    end else if (ctrl.restart) begin
      active <= IS_FIRST;
    end else if (ctrl.step && ctrl.phase == PH_CONSUME) begin
      active <= next_active;
    end
  end

  // code store and pass results
  always_ff @(posedge clk) begin
    if (ctrl.load && len == LW'(IDX)) begin
      code <= ctrl.code;
    end
    if (ctrl.step && ctrl.phase == PH_CLOSURE) begin
      closed <= closed_now;
    end
    if (ctrl.step && ctrl.phase == PH_CHAIN) begin
      in_class <= cin;
    end
  end

endmodule

@@ design/wlm_loader.sv @@
// pattern encoder: turns raw pattern characters into stored codes and
// keeps length, anchor, escape and truncation state; uses wlm_pkg
module wlm_loader #(
  parameter int unsigned PATTERN_DEPTH = wlm_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               append,
  input  logic [7:0]                         char_byte,
  input  logic                               case_fold,
  output logic [$clog2(PATTERN_DEPTH+1)-1:0] len,
  output logic                               anchored,
  output logic                               truncated,
  output logic                               load,
  output logic [7:0]                         code
);
  import wlm_pkg::*;

  localparam int unsigned LW = $clog2(PATTERN_DEPTH + 1);

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_V = 8'h76;
  localparam logic [7:0] CODE_BEL   = 8'd7;
  localparam logic [7:0] CODE_BS    = 8'd8;
  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] CODE_VT    = 8'd11;
  localparam logic [7:0] CODE_FF    = 8'd12;

  logic escape;
  logic last_star;

  logic [LW-1:0] len_next;
  logic          anchored_next, escape_next, truncated_next, last_star_next;
  logic          store;
  logic [7:0]    raw_code;

  // escaped character to code
  function automatic logic [7:0] escape_code(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      CH_LOWER_A: r = CODE_BEL;
      CH_LOWER_B: r = CODE_BS;
      CH_LOWER_F: r = CODE_FF;
      CH_LOWER_T: r = CODE_TAB;
      CH_LOWER_V: r = CODE_VT;
      default:    r = c;
    endcase
    return r;
  endfunction

  // plain character to code
  function automatic logic [7:0] meta_code(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      CH_STAR:   r = CODE_STAR;
      CH_QUEST:  r = CODE_ANY;
      CH_LBRACK: r = CODE_OPEN;
      CH_RBRACK: r = CODE_CLOSE;
      default:   r = c;
    endcase
    return r;
  endfunction

  // encode one character
  always_comb begin
    anchored_next  = anchored;
    escape_next    = escape;
    truncated_next = truncated;
    last_star_next = last_star;
    len_next       = len;
    store          = 1'b0;
    raw_code       = char_byte;
    priority if (escape) begin
      escape_next = 1'b0;
      raw_code    = escape_code(char_byte);
      store       = raw_code != CH_NUL;
    end else if (char_byte == CH_NUL) begin
      store = 1'b0;
    end else if (char_byte == CH_BACKSLASH) begin
      escape_next = 1'b1;
    end else if (char_byte == CH_CARET && len == '0 && !anchored && !truncated) begin
      anchored_next = 1'b1;
    end else if (char_byte == CH_STAR && last_star) begin
      // a star after a stored star adds nothing
      store = 1'b0;
    end else begin
      raw_code = meta_code(char_byte);
      store    = 1'b1;
    end
    code = fold(raw_code, case_fold);
    load = 1'b0;
    if (store) begin
      if (len == LW'(PATTERN_DEPTH)) begin
        truncated_next = 1'b1;
      end else begin
        load           = append;
        len_next       = len + LW'(1);
        last_star_next = code == CODE_STAR;
      end
    end
  end

  // encoder state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      len       <= '0;
      anchored  <= 1'b0;
      escape    <= 1'b0;
      truncated <= 1'b0;
      last_star <= 1'b0;
    end else if (append) begin
      len       <= len_next;
      anchored  <= anchored_next;
      escape    <= escape_next;
      truncated <= truncated_next;
      last_star <= last_star_next;
    end
  end

endmodule

@@ design/wildcard_line_matcher.sv @@
// Wildcard line matcher. Pattern requests (clear, append) and a line-closing
// request finish when accepted; a text byte takes three passes of the shared
// carry unit across the row of pattern cells (star closure in the accepting
// cycle, class scan, then the transition to the next active set) and holds
// off requests until done. A finished result sits in the output register
// while next requests are taken; a second line result waits in a holding slot
// and requests are refused until it moves on. No clearing pass after reset.
module wildcard_line_matcher #(
  parameter int unsigned PATTERN_DEPTH = wlm_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  wlm_in_if.sink          req,
  wlm_out_if.source       res,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);
  import wlm_pkg::*;

  localparam int unsigned LW = $clog2(PATTERN_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAIN,
    S_CONSUME
  } state_t;

  state_t     state;
  logic       case_fold;
  logic       match_seen;
  logic       at_start;
  logic [7:0] text;
  logic       out_valid, out_matched, out_trunc;
  logic       pend_valid, pend_matched, pend_trunc;

  logic [LW-1:0]          len;
  logic                   anchored, truncated, load;
  logic [7:0]             load_code;
  logic                   accept, line_end, text_step, eol_take, out_free;
  logic                   acc_any, acc_closure, result_matched;
  cell_ctrl_t             ctrl;
  cell_stat_t             stat [PATTERN_DEPTH];
  logic [PATTERN_DEPTH-1:0] gen_v, prop_v, cin_v, acc_v;

  // request decode
  assign req.ready = state == S_IDLE && !pend_valid;
  assign accept    = req.valid && req.ready;
  assign line_end  = req.cmd == CMD_EOL ||
                     (req.cmd == CMD_TEXT &&
                      (req.char_byte == CH_NUL || req.char_byte == CH_NEWLINE));
  assign text_step = accept && req.cmd == CMD_TEXT && !line_end;
  assign eol_take  = accept && line_end;
  assign out_free  = !out_valid || res.ready;

  // pattern encoder
  wlm_loader #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_loader (
    .clk       (clk),
    .rst       (rst),
    .clear     (accept && req.cmd == CMD_CLEAR),
    .append    (accept && req.cmd == CMD_APPEND),
    .char_byte (req.char_byte),
    .case_fold (case_fold),
    .len       (len),
    .anchored  (anchored),
    .truncated (truncated),
    .load      (load),
    .code      (load_code)
  );

  // control broadcast to the cells
  always_comb begin
    unique case (state)
      S_IDLE:    ctrl.phase = PH_CLOSURE;
      S_CHAIN:   ctrl.phase = PH_CHAIN;
      S_CONSUME: ctrl.phase = PH_CONSUME;
      default:   ctrl.phase = PH_CLOSURE;
    endcase
    ctrl.step    = text_step || state == S_CHAIN || state == S_CONSUME;
    ctrl.restart = accept && (req.cmd == CMD_CLEAR || req.cmd == CMD_APPEND || line_end);
    ctrl.inject  = !anchored || at_start;
    ctrl.load    = load;
    ctrl.code    = load_code;
    ctrl.text    = text;
  end

  // row of cells, each feeding its advance bit to the right neighbour
  for (genvar i = 0; i < PATTERN_DEPTH; i++) begin : g_cell
    logic adv_left;
    if (i == 0) begin : g_first
      assign adv_left = 1'b0;
    end else begin : g_rest
      assign adv_left = stat[i-1].adv;
    end
    wlm_cell #(.PATTERN_DEPTH(PATTERN_DEPTH), .IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .len      (len),
      .cin      (cin_v[i]),
      .adv_left (adv_left),
      .stat     (stat[i])
    );
    assign gen_v[i]  = stat[i].gen;
    assign prop_v[i] = stat[i].prop;
    assign acc_v[i]  = stat[i].acc;
  end

  // shared carry unit
  wlm_carry #(.WIDTH(PATTERN_DEPTH)) u_carry (
    .gen  (gen_v),
    .prop (prop_v),
    .cin  (cin_v)
  );

  // accept position reached
  assign acc_any        = |acc_v;
  assign acc_closure    = acc_any || len == '0;
  assign result_matched = match_seen || acc_closure;

  // sequencer, line state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      case_fold  <= 1'b0;
      match_seen <= 1'b0;
      at_start   <= 1'b1;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case_fold <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (ctrl.restart) begin
            match_seen <= 1'b0;
            at_start   <= 1'b1;
          end else if (text_step) begin
            match_seen <= match_seen || acc_closure;
            at_start   <= 1'b0;
            text       <= fold(req.char_byte, case_fold);
            state      <= S_CHAIN;
          end
        end
        S_CHAIN: begin
          state <= S_CONSUME;
        end
        S_CONSUME: begin
          match_seen <= match_seen || acc_any;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // output register with one holding slot behind it
      if (out_free) begin
        if (eol_take) begin
          out_valid   <= 1'b1;
          out_matched <= result_matched;
          out_trunc   <= truncated;
        end else if (pend_valid) begin
          out_valid   <= 1'b1;
          out_matched <= pend_matched;
          out_trunc   <= pend_trunc;
          pend_valid  <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (eol_take) begin
        pend_valid   <= 1'b1;
        pend_matched <= result_matched;
        pend_trunc   <= truncated;
      end
    end
  end

  assign res.valid             = out_valid;
  assign res.line_matched      = out_matched;
  assign res.pattern_truncated = out_trunc;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the wildcard line matcher: directed and random requests,
// an in-bench pattern and line predictor, and a scoreboard of expected line results
// depends on wlm_pkg, wlm_in_if, wlm_out_if and wildcard_line_matcher
module testbench;
  import wlm_pkg::*;

  localparam int unsigned PDEPTH       = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 780;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // escaped character values
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  typedef enum logic [1:0] {
    CLOSE_EOL,
    CLOSE_NEWLINE,
    CLOSE_NUL
  } line_end_t;

  typedef struct packed {
    logic matched;
    logic truncated;
  } line_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  wlm_in_if  req_ch ();
  wlm_out_if res_ch ();

  wildcard_line_matcher uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // scoreboard and run control
  line_result_t expected_lines[$];
  int unsigned  fail_count;
  int unsigned  items_sent;
  int unsigned  cycle_count;
  int unsigned  hold_request;
  bit           src_idle_on;
  bit           snk_idle_on;
  logic [7:0]   pat_src[$];
  string        letters = "abcAB$";

  // predictor state
  logic [7:0]        pat_code [PDEPTH];
  int unsigned       pat_len;
  bit                anchored;
  bit                esc_pending;
  bit                truncated;
  bit                match_seen;
  bit                line_start;
  bit                fold_on;
  logic [PDEPTH-1:0] live_pos;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (fold_on && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] esc_value(input logic [7:0] c);
    case (c)
      "a": return CH_BEL;
      "b": return CH_BS;
      "f": return CH_FF;
      "t": return CH_TAB;
      "v": return CH_VT;
      default: return c;
    endcase
  endfunction

  function automatic void line_reset();
    live_pos = '0;
    live_pos[0] = 1'b1;
    match_seen = 1'b0;
    line_start = 1'b1;
  endfunction

  function automatic void pattern_clear();
    pat_len = 0;
    anchored = 1'b0;
    esc_pending = 1'b0;
    truncated = 1'b0;
    line_reset();
  endfunction

  function automatic void pattern_store(input logic [7:0] code);
    if (pat_len >= PDEPTH) begin
      truncated = 1'b1;
    end else begin
      pat_code[pat_len] = code;
      pat_len++;
    end
  endfunction

  // encode one raw pattern character
  function automatic void pattern_append(input logic [7:0] c);
    logic [7:0] code;
    if (esc_pending) begin
      esc_pending = 1'b0;
      code = esc_value(c);
      if (code != CH_NUL) pattern_store(fold_char(code));
      return;
    end
    if (c == CH_NUL) return;
    if (c == CH_BACKSLASH) begin
      esc_pending = 1'b1;
      return;
    end
    if (c == CH_CARET && pat_len == 0 && !anchored && !truncated) begin
      anchored = 1'b1;
      return;
    end
    case (c)
      CH_STAR: begin
        if (pat_len > 0 && pat_code[pat_len-1] == CODE_STAR) return;
        code = CODE_STAR;
      end
      CH_QUEST:  code = CODE_ANY;
      CH_LBRACK: code = CODE_OPEN;
      CH_RBRACK: code = CODE_CLOSE;
      default:   code = c;
    endcase
    pattern_store(fold_char(code));
  endfunction

  // spread stars forward; top bit flags that the accept position was reached
  function automatic logic [PDEPTH:0] spread_stars(input logic [PDEPTH-1:0] s);
    logic acc;
    acc = (pat_len == 0);
    for (int p = 0; p < pat_len; p++) begin
      if (s[p] && pat_code[p] == CODE_STAR) begin
        if (p + 1 < pat_len) s[p+1] = 1'b1;
        else acc = 1'b1;
      end
    end
    return {acc, s};
  endfunction

  // move every live position over one text byte
  function automatic logic [PDEPTH:0] take_byte(input logic [PDEPTH-1:0] cur,
                                                input logic [7:0] c);
    logic [PDEPTH-1:0] nxt;
    logic acc;
    logic hit;
    int q;
    nxt = '0;
    acc = 1'b0;
    for (int p = 0; p < pat_len; p++) begin
      if (cur[p]) begin
        if (pat_code[p] == CODE_STAR) begin
          nxt[p] = 1'b1;
        end else if (pat_code[p] == CODE_ANY) begin
          if (p + 1 >= pat_len) acc = 1'b1;
          else nxt[p+1] = 1'b1;
        end else if (pat_code[p] == CODE_OPEN) begin
          hit = 1'b0;
          for (q = p + 1; q < pat_len; q++) begin
            if (pat_code[q] == CODE_CLOSE) break;
            if (pat_code[q] == c) hit = 1'b1;
          end
          // class with no closing bracket never matches
          if (q < pat_len && hit) begin
            if (q + 1 >= pat_len) acc = 1'b1;
            else nxt[q+1] = 1'b1;
          end
        end else if (pat_code[p] != CODE_CLOSE && pat_code[p] == c) begin
          if (p + 1 >= pat_len) acc = 1'b1;
          else nxt[p+1] = 1'b1;
        end
      end
    end
    return {acc, nxt};
  endfunction

  function automatic void predict_request(input logic [1:0] cmd, input logic [7:0] ch,
                                          output bit has_line, output line_result_t line);
    logic [PDEPTH-1:0] cur;
    logic [PDEPTH:0]   step;
    has_line = 1'b0;
    line = '0;
    case (cmd)
      CMD_CLEAR: pattern_clear();
      CMD_APPEND: begin
        pattern_append(ch);
        line_reset();
      end
      default: begin
        cur = live_pos;
        if (!anchored || line_start) cur[0] = 1'b1;
        step = spread_stars(cur);
        if (step[PDEPTH]) match_seen = 1'b1;
        cur = step[PDEPTH-1:0];
        if (cmd == CMD_TEXT && ch != CH_NEWLINE && ch != CH_NUL) begin
          step = take_byte(cur, fold_char(ch));
          if (step[PDEPTH]) match_seen = 1'b1;
          step = spread_stars(step[PDEPTH-1:0]);
          if (step[PDEPTH]) match_seen = 1'b1;
          live_pos = step[PDEPTH-1:0];
          line_start = 1'b0;
        end else begin
          has_line = 1'b1;
          line.matched = match_seen;
          line.truncated = truncated;
          line_reset();
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 40) begin
      $display("mismatch %s: got %0d, want %0d, cycle %0d", what, got, want, cycle_count);
    end
    fail_count++;
  endtask

  // compare every accepted line result with the oldest expectation
  always @(posedge clk) begin
    line_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("unexpected line result", 1, 0);
      end else begin
        want = expected_lines.pop_front();
        if (res_ch.line_matched !== want.matched) begin
          report_mismatch("line_matched", res_ch.line_matched, want.matched);
        end
        if (res_ch.pattern_truncated !== want.truncated) begin
          report_mismatch("pattern_truncated", res_ch.pattern_truncated, want.truncated);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: random stalls plus the long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned stall;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      stall = snk_idle_on ? pick_gap() : 0;
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall > 0) begin
        res_ch.ready <= 1'b0;
        stall_left = stall - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch);
    int unsigned  gap;
    bit           has_line;
    line_result_t line;
    gap = src_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.char_byte <= ch;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_request(cmd, ch, has_line, line);
    if (has_line) expected_lines.push_back(line);
    items_sent++;
  endtask

  task automatic close_line(input line_end_t how);
    case (how)
      CLOSE_EOL:     send_request(CMD_EOL, 8'($urandom_range(0, 255)));
      CLOSE_NEWLINE: send_request(CMD_TEXT, CH_NEWLINE);
      default:       send_request(CMD_TEXT, CH_NUL);
    endcase
  endtask

  task automatic send_line(input string s, input line_end_t how);
    for (int i = 0; i < s.len(); i++) send_request(CMD_TEXT, s[i]);
    close_line(how);
  endtask

  task automatic load_pattern(input string s);
    send_request(CMD_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < s.len(); i++) send_request(CMD_APPEND, s[i]);
  endtask

  // drop valid and wait until the block has nothing left in hand
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_case_fold(input bit v);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    fold_on = v;
  endtask

  // ---------------------------------------------------------------- directed tests

  task automatic test_literals();
    write_case_fold(1'b0);
    load_pattern("ab");
    send_line("xxaby", CLOSE_EOL);
    send_line("ba", CLOSE_NEWLINE);
    send_line("$a", CLOSE_NUL);
  endtask

  task automatic test_anchor_and_stars();
    load_pattern("^a**b");
    send_line("aaab", CLOSE_EOL);
    send_line("caab", CLOSE_NUL);
    // second caret is a literal
    load_pattern("^^x");
    send_line("^x", CLOSE_EOL);
  endtask

  task automatic test_any_and_class();
    load_pattern("a?c");
    send_line("zabc", CLOSE_EOL);
    send_line("ac", CLOSE_EOL);
    // metacharacters inside a class only match their code byte
    load_pattern("[x*?]q");
    send_line("\001q", CLOSE_EOL);
    send_line("*q", CLOSE_NEWLINE);
  endtask

  task automatic test_escapes();
    load_pattern("\\t\\a\\b\\f\\v\\\\\\q$");
    send_line("\t\007\010\014\013\\q$", CLOSE_EOL);
    // raw and escaped nul are dropped, trailing backslash is harmless
    send_request(CMD_APPEND, CH_NUL);
    send_request(CMD_APPEND, CH_BACKSLASH);
    send_request(CMD_APPEND, CH_NUL);
    send_request(CMD_APPEND, CH_BACKSLASH);
    send_line("\t\007\010\014\013\\q$", CLOSE_EOL);
  endtask

  task automatic test_broken_classes();
    load_pattern("[ab");
    send_line("a", CLOSE_EOL);
    load_pattern("a]b");
    send_line("a]b", CLOSE_EOL);
  endtask

  task automatic test_control_bytes();
    load_pattern("\001\002\003x\004");
    send_line("zzx", CLOSE_EOL);
    send_line("z", CLOSE_EOL);
  endtask

  task automatic test_empty_pattern();
    load_pattern("");
    send_line("", CLOSE_EOL);
    send_line("", CLOSE_NEWLINE);
    send_line("qq", CLOSE_NUL);
  endtask

  task automatic test_mid_line_change();
    load_pattern("ab");
    send_request(CMD_TEXT, "a");
    send_request(CMD_APPEND, "c");
    send_line("abc", CLOSE_EOL);
    send_request(CMD_TEXT, "x");
    send_request(CMD_CLEAR, 8'h00);
    close_line(CLOSE_EOL);
  endtask

  task automatic test_full_store();
    send_request(CMD_CLEAR, 8'hFF);
    for (int i = 0; i < PDEPTH + 6; i++) send_request(CMD_APPEND, (i % 2) ? "k" : "m");
    send_request(CMD_APPEND, CH_CARET);
    send_line("mkmk", CLOSE_EOL);
    send_request(CMD_CLEAR, 8'h00);
    close_line(CLOSE_EOL);
  endtask

  task automatic test_case_fold();
    write_case_fold(1'b1);
    load_pattern("AbC");
    send_line("xaBcX", CLOSE_EOL);
    load_pattern("[Q]");
    send_line("q", CLOSE_EOL);
    write_case_fold(1'b0);
    load_pattern("abc");
    send_line("xaBcX", CLOSE_EOL);
  endtask

  // result side holds off while requests keep coming, so the input stalls
  task automatic test_back_pressure();
    settle();
    src_idle_on = 1'b0;
    load_pattern("a*b");
    hold_request = 200;
    repeat (24) send_line("ab", CLOSE_EOL);
    src_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- random traffic

  function automatic logic [7:0] random_letter();
    return letters[$urandom_range(0, 4)];
  endfunction

  function automatic logic [7:0] pick_pattern_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return letters[$urandom_range(0, 5)];
    if (r < 52) return CH_STAR;
    if (r < 60) return CH_QUEST;
    if (r < 67) return CH_LBRACK;
    if (r < 74) return CH_RBRACK;
    if (r < 82) return CH_BACKSLASH;
    if (r < 87) return CH_CARET;
    if (r < 91) return 8'($urandom_range(1, 4));
    if (r < 93) return CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  // send a text byte with occasional corruption and case flips
  task automatic emit_text(input logic [7:0] c);
    if ($urandom_range(0, 9) == 0) c = random_letter();
    if (((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= "a" && c <= "z"))
        && $urandom_range(0, 3) == 0) begin
      c = c ^ CASE_OFFSET;
    end
    if (c == CH_NEWLINE || c == CH_NUL) c = "x";
    send_request(CMD_TEXT, c);
  endtask

  task automatic random_pattern();
    int unsigned n;
    logic [7:0]  c;
    send_request(CMD_CLEAR, 8'($urandom_range(0, 255)));
    pat_src.delete();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 8);
    repeat (n) begin
      c = pick_pattern_char();
      pat_src.push_back(c);
      send_request(CMD_APPEND, c);
    end
  endtask

  // a line shaped after the raw pattern, so that many lines match
  task automatic random_line();
    int i;
    logic [7:0] c;
    i = 0;
    if (pat_src.size() > 0 && pat_src[0] == CH_CARET) i = 1;
    else repeat ($urandom_range(0, 2)) emit_text(random_letter());
    while (i < pat_src.size()) begin
      c = pat_src[i];
      if (c == CH_BACKSLASH) begin
        if (i + 1 < pat_src.size()) emit_text(esc_value(pat_src[i+1]));
        i += 2;
      end else if (c == CH_STAR) begin
        repeat ($urandom_range(0, 2)) emit_text(random_letter());
        i++;
      end else if (c == CH_QUEST) begin
        emit_text(random_letter());
        i++;
      end else if (c == CH_LBRACK) begin
        i++;
        if (i < pat_src.size() && pat_src[i] != CH_RBRACK) emit_text(pat_src[i]);
        while (i < pat_src.size() && pat_src[i] != CH_RBRACK) i++;
        i++;
      end else begin
        emit_text(c);
        i++;
      end
    end
    repeat ($urandom_range(0, 2)) emit_text(random_letter());
    close_line(line_end_t'($urandom_range(0, 2)));
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned phase_end;
    bit          fold_next;
    start = items_sent;
    fold_next = 1'b1;
    phase_end = items_sent + 250;
    while (items_sent - start < RANDOM_ITEMS) begin
      // new case fold setting every few hundred requests
      if (items_sent >= phase_end) begin
        write_case_fold(fold_next);
        fold_next = !fold_next;
        phase_end = items_sent + 250;
      end
      if ($urandom_range(0, 9) == 0) begin
        src_idle_on = ($urandom_range(0, 3) != 0);
        snk_idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < 85) begin
        random_pattern();
        repeat ($urandom_range(1, 4)) random_line();
        if ($urandom_range(0, 19) == 0) begin
          send_request(CMD_TEXT, random_letter());
          send_request(CMD_APPEND, pick_pattern_char());
        end
      end else begin
        repeat ($urandom_range(4, 16)) begin
          send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_CLEAR;
    req_ch.char_byte = 8'h00;
    fail_count = 0;
    items_sent = 0;
    cycle_count = 0;
    hold_request = 0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    fold_on = 1'b0;
    pattern_clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_literals();
    test_anchor_and_stars();
    test_any_and_class();
    test_escapes();
    test_broken_classes();
    test_control_bytes();
    test_empty_pattern();
    test_mid_line_change();
    test_full_store();
    test_case_fold();
    test_back_pressure();
    test_random_traffic();

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ wildcard_line_matcher.f @@
design/wlm_pkg.sv
design/wlm_in_if.sv
design/wlm_out_if.sv
design/wlm_carry.sv
design/wlm_cell.sv
design/wlm_loader.sv
design/wildcard_line_matcher.sv
verif/testbench.sv
